FILE: rtl/core/bcd_clock_register_file_unit_defines.svh
// Assertion macros used by the checker file.
`ifndef BCD_CLOCK_REGISTER_FILE_UNIT_DEFINES_SVH
`define BCD_CLOCK_REGISTER_FILE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clock, off while reset is high.
`define BCDCLK_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("bcdclk: same-cycle check failed");

// Next-cycle implication, sampled on clock, off while reset is high.
`define BCDCLK_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("bcdclk: next-cycle check failed");

`endif

FILE: rtl/core/bcdclk_pkg.sv
`timescale 1ns / 1ps
package bcdclk_pkg;

   localparam int BCDCLK_RAM_WORDS = 13;

   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 8;

   typedef enum logic {
      KIND_READ  = 1'b0,
      KIND_WRITE = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      MODE_TIME = 2'd0,
      MODE_SEL  = 2'd1,
      MODE_LOW  = 2'd2,
      MODE_HIGH = 2'd3
   } bank_mode_type;

   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_HALF = 3'd2;
   localparam logic [1:0] LANE_BYTE = 2'd3;
   localparam logic [1:0] LANE_HALF = 2'd2;

   localparam logic [3:0] REG_SEC_UNITS  = 4'd0;
   localparam logic [3:0] REG_SEC_TENS   = 4'd1;
   localparam logic [3:0] REG_MIN_UNITS  = 4'd2;
   localparam logic [3:0] REG_MIN_TENS   = 4'd3;
   localparam logic [3:0] REG_HR_UNITS   = 4'd4;
   localparam logic [3:0] REG_HR_TENS    = 4'd5;
   localparam logic [3:0] REG_WEEKDAY    = 4'd6;
   localparam logic [3:0] REG_DAY_UNITS  = 4'd7;
   localparam logic [3:0] REG_DAY_TENS   = 4'd8;
   localparam logic [3:0] REG_MON_UNITS  = 4'd9;
   localparam logic [3:0] REG_MON_TENS   = 4'd10;
   localparam logic [3:0] REG_YEAR_UNITS = 4'd11;
   localparam logic [3:0] REG_YEAR_TENS  = 4'd12;
   localparam logic [3:0] REG_HOUR_SEL   = 4'd10;
   localparam logic [3:0] REG_MODE       = 4'd13;

   localparam logic [3:0] TIMER_BIT = 4'h8;

   typedef struct packed {
      logic [7:0] year;
      logic [3:0] month;
      logic [4:0] monthday;
      logic [2:0] weekday;
      logic [4:0] hours;
      logic [5:0] minutes;
      logic [5:0] seconds;
   } time_type;

   // x / 10 for x < 256 by reciprocal multiply
   function automatic logic [4:0] tens_of(input logic [7:0] x);
      logic [18:0] p;
      begin
         p = 19'(x) * 19'd205;
         return p[15:11];
      end
   endfunction

   function automatic logic [3:0] units_of(input logic [7:0] x);
      logic [7:0] q10;
      begin
         q10 = 8'(tens_of(x)) * 8'd10;
         return 4'(x - q10);
      end
   endfunction

endpackage

FILE: rtl/core/bcdclk_time_digits.sv
`timescale 1ns / 1ps
module bcdclk_time_digits
   import bcdclk_pkg::*;
(
   input  time_type   now,
   input  logic [3:0] reg_idx,
   input  logic       hour_24,
   output logic [3:0] digit
);

   logic [4:0] twelve;
   logic       pm;
   logic [7:0] hr8;
   logic [7:0] tw8;
   logic [7:0] mon8;

   always_comb begin
      pm   = (now.hours >= 5'd12);
      if (now.hours == 5'd0) begin
         twelve = 5'd12;
      end else if (now.hours > 5'd12) begin
         twelve = now.hours - 5'd12;
      end else begin
         twelve = now.hours;
      end
      hr8  = 8'(now.hours);
      tw8  = 8'(twelve);
      mon8 = 8'(now.month) + 8'd1;

      case (reg_idx)
         REG_SEC_UNITS:  digit = units_of(8'(now.seconds));
         REG_SEC_TENS:   digit = 4'(tens_of(8'(now.seconds)));
         REG_MIN_UNITS:  digit = units_of(8'(now.minutes));
         REG_MIN_TENS:   digit = 4'(tens_of(8'(now.minutes)));
         REG_HR_UNITS:   digit = hour_24 ? units_of(hr8) : units_of(tw8);
         REG_HR_TENS:    digit = hour_24 ? 4'(tens_of(hr8))
                                         : (4'(tens_of(tw8)) | {2'b00, pm, 1'b0});
         REG_WEEKDAY:    digit = 4'(now.weekday);
         REG_DAY_UNITS:  digit = units_of(8'(now.monthday));
         REG_DAY_TENS:   digit = 4'(tens_of(8'(now.monthday)));
         REG_MON_UNITS:  digit = units_of(mon8);
         REG_MON_TENS:   digit = 4'(tens_of(mon8));
         REG_YEAR_UNITS: digit = units_of(now.year);
         REG_YEAR_TENS:  digit = units_of(8'(tens_of(now.year)));
         default:        digit = 4'd0;
      endcase
   end

endmodule

FILE: rtl/core/bcdclk_rsp_reg.sv
`timescale 1ns / 1ps
module bcdclk_rsp_reg
   import bcdclk_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  logic [3:0]            load_data,
   output logic                  can_load,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic       valid_ff;
   logic       valid_in;
   logic [3:0] data_ff;

   // slot frees up in the same cycle the sink takes the beat
   assign can_load = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-4){1'b0}}, data_ff};

endmodule

FILE: rtl/core/bcd_clock_register_file_unit.sv
`timescale 1ns / 1ps
// channel | dir | beat fields
// req_*   | in  | tuser: kind; tdata: offset, size, wdata, time fields
// rsp_*   | out | tdata: read_data (one beat per read, none per write)
//
// One access per cycle sustained while no read waits on the result register; a read
// answers through the input register, then the result register.
// Reset clears bank mode, selects 24-hour form and zeroes the nibble RAM.
// A read held in the input register waits while the result register is full
// and not taken; then req_tready drops. Writes never wait on the result side.
module bcd_clock_register_file_unit
   import bcdclk_pkg::*;
#(
   parameter int RAM_WORDS = BCDCLK_RAM_WORDS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // [0] kind
   input  logic [0:0]            req_tuser,
   // [5:0] bus_offset, [8:6] access_size, [16:9] write_data, [22:17] now_seconds,
   // [28:23] now_minutes, [33:29] now_hours, [36:34] now_weekday,
   // [41:37] now_monthday, [45:42] now_month, [53:46] now_year, [55:54] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // [3:0] read_data, [7:4] zero
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int RamAw = $clog2(RAM_WORDS);

   logic          s1_valid_ff;
   kind_type      s1_kind_ff;
   logic [5:0]    s1_offset_ff;
   logic [2:0]    s1_size_ff;
   logic [7:0]    s1_wdata_ff;
   time_type      s1_time_ff;

   bank_mode_type bank_mode_ff;
   logic          hour_24_ff;
   logic [7:0]    ram_ff [RAM_WORDS];

   logic          s1_go;
   logic          rsp_can_load;
   logic [3:0]    reg_idx;
   logic [1:0]    lane;
   logic          bad;
   logic          in_ram;
   logic [RamAw-1:0] ram_idx;
   logic [7:0]    ram_word;
   logic [3:0]    time_digit;
   logic [3:0]    read_nibble;
   logic          do_write;

   assign s1_go      = s1_valid_ff && ((s1_kind_ff == KIND_WRITE) || rsp_can_load);
   assign req_tready = !s1_valid_ff || s1_go;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         s1_kind_ff   <= kind_type'(req_tuser[0]);
         s1_offset_ff <= req_tdata[5:0];
         s1_size_ff   <= req_tdata[8:6];
         s1_wdata_ff  <= req_tdata[16:9];
         s1_time_ff   <= time_type'(req_tdata[53:17]);
      end
   end

   assign reg_idx  = s1_offset_ff[5:2];
   assign lane     = s1_offset_ff[1:0];
   assign bad      = ((s1_size_ff == SIZE_BYTE) && (lane != LANE_BYTE)) ||
                     ((s1_size_ff == SIZE_HALF) && (lane != LANE_HALF));
   assign in_ram   = (32'(reg_idx) < RAM_WORDS);
   assign ram_idx  = reg_idx[RamAw-1:0];
   assign ram_word = in_ram ? ram_ff[ram_idx] : 8'h00;
   assign do_write = s1_go && (s1_kind_ff == KIND_WRITE) && !bad;

   bcdclk_time_digits u_digits (
      .now     (s1_time_ff),
      .reg_idx (reg_idx),
      .hour_24 (hour_24_ff),
      .digit   (time_digit)
   );

   always_comb begin
      read_nibble = 4'd0;
      if (!bad) begin
         if (reg_idx == REG_MODE) begin
            read_nibble = TIMER_BIT | {2'b00, bank_mode_ff};
         end else if (reg_idx < REG_MODE) begin
            case (bank_mode_ff)
               MODE_TIME: read_nibble = time_digit;
               MODE_SEL:  read_nibble = (reg_idx == REG_HOUR_SEL) ? {3'b000, hour_24_ff}
                                                                  : 4'd0;
               MODE_LOW:  read_nibble = ram_word[3:0];
               MODE_HIGH: read_nibble = ram_word[7:4];
               default:   read_nibble = 4'd0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_mode_ff <= MODE_TIME;
         hour_24_ff   <= 1'b1;
         for (int i = 0; i < RAM_WORDS; i++) begin
            ram_ff[i] <= 8'h00;
         end
      end else if (do_write) begin
         if (reg_idx == REG_MODE) begin
            bank_mode_ff <= bank_mode_type'(s1_wdata_ff[1:0]);
         end else if (reg_idx < REG_MODE) begin
            if (bank_mode_ff == MODE_SEL) begin
               if (reg_idx == REG_HOUR_SEL) begin
                  hour_24_ff <= s1_wdata_ff[0];
               end
            end else if (bank_mode_ff == MODE_LOW && in_ram) begin
               ram_ff[ram_idx] <= {ram_ff[ram_idx][7:4], s1_wdata_ff[3:0]};
            end else if (bank_mode_ff == MODE_HIGH && in_ram) begin
               ram_ff[ram_idx] <= {s1_wdata_ff[3:0], ram_ff[ram_idx][3:0]};
            end
         end
      end
   end

   bcdclk_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (s1_go && (s1_kind_ff == KIND_READ)),
      .load_data  (read_nibble),
      .can_load   (rsp_can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: rtl/core/bcdclk_checker.sv
`timescale 1ns / 1ps
`include "bcd_clock_register_file_unit_defines.svh"
module bcdclk_checker
   import bcdclk_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   // stalled result beat holds
   `BCDCLK_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // only a nibble is ever returned
   `BCDCLK_ASSERT_IMPLY(a_rsp_nibble, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:4] == '0)

   // input side stalls only behind a blocked result beat
   `BCDCLK_ASSERT_IMPLY(a_stall_cause, !req_tready, rsp_tvalid && !rsp_tready)

   // no result beat right out of reset
   `BCDCLK_ASSERT_IMPLY(a_reset_empty, $past(reset), !rsp_tvalid)

endmodule

bind bcd_clock_register_file_unit bcdclk_checker u_bcdclk_checker (.*);
